>>> hw/rtl/hfl_pkg.sv
// Shared types, widths and codes for the handler free-list allocator.
// Used by hfl_ring, handler_free_list_with_overload_core and the dv files; no dependencies.
package hfl_pkg;

  localparam int MAX_HANDLERS = 256;
  localparam int PTR_W        = $clog2(MAX_HANDLERS);
  localparam int CNT_W        = PTR_W + 1;
  localparam int ID_W         = 8;
  localparam int CFG_W        = 9;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_HANDLERS);

  // Request codes.
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HANDLERS_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_BUSY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_BUSY    = 2'd2;

  localparam logic [CFG_W-1:0] HANDLERS_TOTAL_RST = 9'd256;
  localparam logic [CFG_W-1:0] CRITICAL_BUSY_RST  = 9'd256;
  localparam logic [CFG_W-1:0] NORMAL_BUSY_RST    = 9'd192;

  // Write and read request toward the ring storage.
  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [ID_W-1:0]  wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } ring_req_t;

  // Busy handlers for a given free count, clamped at zero.
  function automatic logic [CFG_W-1:0] busy_calc(input logic [CFG_W-1:0] total,
                                                 input logic [CNT_W-1:0] free_cnt);
    logic [CFG_W-1:0] fc;
    fc = CFG_W'(free_cnt);
    if (fc >= total) begin
      return '0;
    end
    return total - fc;
  endfunction

endpackage

>>> hw/rtl/hfl_ring.sv
// Ring storage of free handler IDs: one write and one registered read per cycle.
// Depends on hfl_pkg for widths and the request struct.
module hfl_ring (
  input  logic                     clk,
  input  hfl_pkg::ring_req_t       req,
  output logic [hfl_pkg::ID_W-1:0] rd_data
);

  logic [hfl_pkg::ID_W-1:0] mem [hfl_pkg::MAX_HANDLERS];
  logic [hfl_pkg::ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/handler_free_list_with_overload_core.sv
// Top level of the handler free-list allocator with hysteresis overload alarm.
// Depends on hfl_pkg and hfl_ring.

// The block takes one item in every clock cycle: busy is always low, so an item is
// accepted whenever start is high. Each item gives exactly one result, shown on the out_
// ports for one cycle with out_valid high, in the cycle after the item is accepted. The
// receiver cannot stall, so results must be taken as they come. The read data of the ring
// memory is registered like the other result fields; pointers, free count and the
// overload flag are all updated at the accepting edge, so the next item sees the new
// state at once. The free list is empty after reset and needs no clearing pass: every ID
// handed out was first placed in the list by a release.
module handler_free_list_with_overload_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // Item input.
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [hfl_pkg::ID_W-1:0]      in_handler_id,
  // Results.
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [hfl_pkg::ID_W-1:0]      out_granted_id,
  output logic                          out_none_free,
  output logic                          out_release_dropped,
  output logic [hfl_pkg::CFG_W-1:0]     out_busy_count,
  output logic                          out_overload,
  output logic                          out_alarm_raise,
  output logic                          out_alarm_clear,
  // Configuration.
  input  logic                          cfg_we,
  input  logic [hfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfl_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [hfl_pkg::CFG_W-1:0] total_r, crit_r, normal_r;

  // List state.
  logic [hfl_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [hfl_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [hfl_pkg::CNT_W-1:0] free_r, free_nxt;
  logic                      ovl_r, ovl_nxt;

  // Result register.
  logic                      valid_r;
  logic                      granted_r, granted_nxt;
  logic                      none_r, none_nxt;
  logic                      dropped_r, dropped_nxt;
  logic [hfl_pkg::CFG_W-1:0] bcnt_r, bcnt_nxt;
  logic                      raise_r, raise_nxt;
  logic                      clear_r, clear_nxt;

  logic                      accept;
  logic                      list_empty, list_full;
  logic [hfl_pkg::CFG_W-1:0] busy_after;
  hfl_pkg::ring_req_t        ring_req;
  logic [hfl_pkg::ID_W-1:0]  ring_rd_data;

  // The block never holds off an item.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign list_empty = (free_r == '0);
  assign list_full  = (free_r == hfl_pkg::FULL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= hfl_pkg::HANDLERS_TOTAL_RST;
      crit_r   <= hfl_pkg::CRITICAL_BUSY_RST;
      normal_r <= hfl_pkg::NORMAL_BUSY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hfl_pkg::CFG_HANDLERS_TOTAL: total_r  <= cfg_wdata;
        hfl_pkg::CFG_CRITICAL_BUSY:  crit_r   <= cfg_wdata;
        hfl_pkg::CFG_NORMAL_BUSY:    normal_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state of the list and the overload flag for the item being accepted.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    free_nxt    = free_r;
    ovl_nxt     = ovl_r;
    granted_nxt = 1'b0;
    none_nxt    = 1'b0;
    dropped_nxt = 1'b0;
    raise_nxt   = 1'b0;
    clear_nxt   = 1'b0;
    ring_req    = '0;

    if (in_req_type == hfl_pkg::REQ_ALLOC) begin
      if (list_empty) begin
        none_nxt = 1'b1;
      end else begin
        granted_nxt      = 1'b1;
        head_nxt         = head_r + 1'b1;
        free_nxt         = free_r - 1'b1;
        ring_req.rd_en   = accept;
        ring_req.rd_addr = head_r;
      end
    end else begin
      if (list_full) begin
        dropped_nxt = 1'b1;
      end else begin
        tail_nxt         = tail_r + 1'b1;
        free_nxt         = free_r + 1'b1;
        ring_req.wr_en   = accept;
        ring_req.wr_addr = tail_r;
        ring_req.wr_data = in_handler_id;
      end
    end

    busy_after = hfl_pkg::busy_calc(total_r, free_nxt);
    bcnt_nxt   = busy_after;

    // Hysteresis: only a granted allocate may raise, and any release may clear,
    // even one that was dropped.
    if (granted_nxt && !ovl_r && (busy_after >= crit_r)) begin
      ovl_nxt   = 1'b1;
      raise_nxt = 1'b1;
    end
    if ((in_req_type == hfl_pkg::REQ_RELEASE) && ovl_r && (busy_after <= normal_r)) begin
      ovl_nxt   = 1'b0;
      clear_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= '0;
      ovl_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        free_r <= free_nxt;
        ovl_r  <= ovl_nxt;
      end
    end
  end

  // Result payload; it is only looked at while valid_r is high.
  always_ff @(posedge clk) begin
    if (accept) begin
      granted_r <= granted_nxt;
      none_r    <= none_nxt;
      dropped_r <= dropped_nxt;
      bcnt_r    <= bcnt_nxt;
      raise_r   <= raise_nxt;
      clear_r   <= clear_nxt;
    end
  end

  hfl_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd_data)
  );

  // The flag register already holds the value after the item that is being shown.
  assign out_valid           = valid_r;
  assign out_granted         = granted_r;
  assign out_granted_id      = granted_r ? ring_rd_data : '0;
  assign out_none_free       = none_r;
  assign out_release_dropped = dropped_r;
  assign out_busy_count      = bcnt_r;
  assign out_overload        = ovl_r;
  assign out_alarm_raise     = raise_r;
  assign out_alarm_clear     = clear_r;

endmodule

>>> dv/handler_grant_checker.sv
// Checker for the handler free-list allocator: predicts every result and compares it.
// Depends on hfl_pkg for widths, request codes, register indexes and reset values.
module handler_grant_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_req_type,
  input  logic [hfl_pkg::ID_W-1:0]      in_handler_id,
  input  logic                          out_valid,
  input  logic                          out_granted,
  input  logic [hfl_pkg::ID_W-1:0]      out_granted_id,
  input  logic                          out_none_free,
  input  logic                          out_release_dropped,
  input  logic [hfl_pkg::CFG_W-1:0]     out_busy_count,
  input  logic                          out_overload,
  input  logic                          out_alarm_raise,
  input  logic                          out_alarm_clear,
  input  logic                          cfg_we,
  input  logic [hfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfl_pkg::CFG_W-1:0]     cfg_wdata,
  output int                            mismatch_count,
  output int                            results_pending
);

  typedef struct packed {
    logic                      granted;
    logic [hfl_pkg::ID_W-1:0]  granted_id;
    logic                      none_free;
    logic                      release_dropped;
    logic [hfl_pkg::CFG_W-1:0] busy_count;
    logic                      overload;
    logic                      alarm_raise;
    logic                      alarm_clear;
  } grant_result_t;

  logic [hfl_pkg::ID_W-1:0]  free_ids [hfl_pkg::MAX_HANDLERS];
  logic [hfl_pkg::PTR_W-1:0] head_idx;
  logic [hfl_pkg::PTR_W-1:0] tail_idx;
  logic [hfl_pkg::CNT_W-1:0] free_cnt;
  logic                      overloaded;
  logic [hfl_pkg::CFG_W-1:0] total_lim;
  logic [hfl_pkg::CFG_W-1:0] critical_lim;
  logic [hfl_pkg::CFG_W-1:0] normal_lim;
  grant_result_t             pending_grants [$];
  int                        errors = 0;

  // Handlers in use, never below zero when more IDs are free than the total.
  function automatic logic [hfl_pkg::CFG_W-1:0] handlers_in_use();
    logic [hfl_pkg::CFG_W-1:0] free_ext;
    free_ext = hfl_pkg::CFG_W'(free_cnt);
    return (free_ext < total_lim) ? total_lim - free_ext : '0;
  endfunction

  function automatic grant_result_t serve_request(input logic req,
                                                  input logic [hfl_pkg::ID_W-1:0] id);
    grant_result_t r;
    r = '0;
    if (req == hfl_pkg::REQ_ALLOC) begin
      if (free_cnt == '0) begin
        r.none_free = 1'b1;
      end else begin
        r.granted    = 1'b1;
        r.granted_id = free_ids[head_idx];
        head_idx     = head_idx + 1'b1;
        free_cnt     = free_cnt - 1'b1;
        if (!overloaded && handlers_in_use() >= critical_lim) begin
          overloaded    = 1'b1;
          r.alarm_raise = 1'b1;
        end
      end
    end else begin
      if (free_cnt >= hfl_pkg::FULL_COUNT) begin
        r.release_dropped = 1'b1;
      end else begin
        free_ids[tail_idx] = id;
        tail_idx           = tail_idx + 1'b1;
        free_cnt           = free_cnt + 1'b1;
      end
      // The clear test runs even when the release was dropped.
      if (overloaded && handlers_in_use() <= normal_lim) begin
        overloaded    = 1'b0;
        r.alarm_clear = 1'b1;
      end
    end
    r.busy_count = handlers_in_use();
    r.overload   = overloaded;
    return r;
  endfunction

  function automatic string describe(input grant_result_t r);
    return $sformatf({"granted=%0d id=%0d none_free=%0d dropped=%0d ",
                      "busy=%0d ovl=%0d raise=%0d clear=%0d"},
                     r.granted, r.granted_id, r.none_free, r.release_dropped,
                     r.busy_count, r.overload, r.alarm_raise, r.alarm_clear);
  endfunction

  task automatic report_failure(input string what, input string detail);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: %s", $time, what, detail);
    end
  endtask

  always @(posedge clk) begin : track_grants
    grant_result_t seen;
    grant_result_t wanted;
    if (!rst_n) begin
      head_idx     = '0;
      tail_idx     = '0;
      free_cnt     = '0;
      overloaded   = 1'b0;
      total_lim    = hfl_pkg::HANDLERS_TOTAL_RST;
      critical_lim = hfl_pkg::CRITICAL_BUSY_RST;
      normal_lim   = hfl_pkg::NORMAL_BUSY_RST;
      pending_grants.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hfl_pkg::CFG_HANDLERS_TOTAL: total_lim    = cfg_wdata;
          hfl_pkg::CFG_CRITICAL_BUSY:  critical_lim = cfg_wdata;
          hfl_pkg::CFG_NORMAL_BUSY:    normal_lim   = cfg_wdata;
          default: ;
        endcase
      end
      // The new item goes in first so that a result in the same cycle still meets the
      // oldest expectation.
      if (start && !busy) begin
        pending_grants.push_back(serve_request(in_req_type, in_handler_id));
      end
      if (out_valid) begin
        seen = {out_granted, out_granted_id, out_none_free, out_release_dropped,
                out_busy_count, out_overload, out_alarm_raise, out_alarm_clear};
        if (pending_grants.size() == 0) begin
          report_failure("result with no item outstanding", describe(seen));
        end else begin
          wanted = pending_grants.pop_front();
          if (seen !== wanted) begin
            report_failure("result mismatch",
                           $sformatf("expected %s, got %s", describe(wanted), describe(seen)));
          end
        end
      end
    end
    results_pending <= pending_grants.size();
    mismatch_count  <= errors;
  end

endmodule

>>> dv/handler_free_list_with_overload_core_tb.sv
// Top of the testbench for handler_free_list_with_overload_core: clock, reset, stimulus
// and verdict. Depends on hfl_pkg, the block itself and handler_grant_checker.
module handler_free_list_with_overload_core_tb;

  // Cycles in a row with no item and no result before the run is declared hung. The
  // longest correct quiet stretch is a random sender gap or a drain pause, both far shorter.
  localparam int STALL_LIMIT = 1000;

  // The register index that no register answers to; writes to it must change nothing.
  localparam logic [hfl_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          start         = 1'b0;
  logic                          busy;
  logic                          in_req_type   = hfl_pkg::REQ_ALLOC;
  logic [hfl_pkg::ID_W-1:0]      in_handler_id = '0;
  logic                          out_valid;
  logic                          out_granted;
  logic [hfl_pkg::ID_W-1:0]      out_granted_id;
  logic                          out_none_free;
  logic                          out_release_dropped;
  logic [hfl_pkg::CFG_W-1:0]     out_busy_count;
  logic                          out_overload;
  logic                          out_alarm_raise;
  logic                          out_alarm_clear;
  logic                          cfg_we        = 1'b0;
  logic [hfl_pkg::CFG_IDX_W-1:0] cfg_index     = hfl_pkg::CFG_HANDLERS_TOTAL;
  logic [hfl_pkg::CFG_W-1:0]     cfg_wdata     = '0;

  int mismatch_count;
  int results_pending;
  int sender_idle_pct = 0;
  int stall_cycles    = 0;

  always #2 clk = ~clk;

  handler_free_list_with_overload_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_handler_id       (in_handler_id),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_granted_id      (out_granted_id),
    .out_none_free       (out_none_free),
    .out_release_dropped (out_release_dropped),
    .out_busy_count      (out_busy_count),
    .out_overload        (out_overload),
    .out_alarm_raise     (out_alarm_raise),
    .out_alarm_clear     (out_alarm_clear),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // The checker sees the same edges as the block and keeps its own copy of the list.
  handler_grant_checker grant_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_handler_id       (in_handler_id),
    .out_valid           (out_valid),
    .out_granted         (out_granted),
    .out_granted_id      (out_granted_id),
    .out_none_free       (out_none_free),
    .out_release_dropped (out_release_dropped),
    .out_busy_count      (out_busy_count),
    .out_overload        (out_overload),
    .out_alarm_raise     (out_alarm_raise),
    .out_alarm_clear     (out_alarm_clear),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatch_count),
    .results_pending     (results_pending)
  );

  // Watchdog: any accepted item or result restarts the count. Values read here are the
  // ones from before the edge, since every driver updates with nonblocking assignments.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one item and returns right after the edge that accepts it. Before the item the
  // sender may sit idle for a random number of cycles. When no gap is taken, start simply
  // stays high, so it gets only one assignment per edge.
  task automatic issue_request(input logic req, input logic [hfl_pkg::ID_W-1:0] id);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_req_type   <= req;
    in_handler_id <= id;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every item has given its result. Every item yields a
  // result, so the block is then fully idle before registers change.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    wait (results_pending == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [hfl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hfl_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Writes all three thresholds back to back, then drops the write enable.
  task automatic set_limits(input logic [hfl_pkg::CFG_W-1:0] total,
                            input logic [hfl_pkg::CFG_W-1:0] critical,
                            input logic [hfl_pkg::CFG_W-1:0] normal);
    write_limit(hfl_pkg::CFG_HANDLERS_TOTAL, total);
    write_limit(hfl_pkg::CFG_CRITICAL_BUSY, critical);
    write_limit(hfl_pkg::CFG_NORMAL_BUSY, normal);
    cfg_we <= 1'b0;
  endtask

  // A run of random items. The release share steers the list toward full or toward
  // empty; handler IDs cover all eight bits.
  task automatic random_burst(input int count, input int release_pct);
    repeat (count) begin
      issue_request(($urandom_range(99) < release_pct) ? hfl_pkg::REQ_RELEASE
                                                       : hfl_pkg::REQ_ALLOC,
                    hfl_pkg::ID_W'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset thresholds still in force. The list starts empty, so the first allocate must
    // report that no handler is free; its ID is ignored.
    issue_request(hfl_pkg::REQ_ALLOC, 8'h5A);
    issue_request(hfl_pkg::REQ_RELEASE, 8'h00);
    drain_results();

    // A write to the unused index must leave every threshold alone. Then a tiny pool of
    // four handlers makes the alarm easy to reach.
    write_limit(CFG_UNMAPPED, 9'd100);
    set_limits(9'd4, 9'd3, 9'd1);

    // Five free IDs against a total of four: the busy count clamps at zero.
    issue_request(hfl_pkg::REQ_RELEASE, 8'hFF);
    issue_request(hfl_pkg::REQ_RELEASE, 8'hAA);
    issue_request(hfl_pkg::REQ_RELEASE, 8'h55);
    issue_request(hfl_pkg::REQ_RELEASE, 8'h01);
    // Grants come back in release order. The fourth grant takes the busy count to the
    // critical level and raises the alarm; the fifth leaves the flag set.
    repeat (5) issue_request(hfl_pkg::REQ_ALLOC, 8'h00);
    // Allocate on an empty list while overloaded: no grant, and no alarm change.
    issue_request(hfl_pkg::REQ_ALLOC, 8'hC3);
    // Releases walk the count down; only the one reaching the normal level clears.
    issue_request(hfl_pkg::REQ_RELEASE, 8'h80);
    issue_request(hfl_pkg::REQ_RELEASE, 8'h7F);
    issue_request(hfl_pkg::REQ_RELEASE, 8'h3C);
    drain_results();

    // Fill phase: mostly releases, so the list wraps, fills to the brim and then drops
    // releases. Busy falls from near the top, crossing both thresholds.
    sender_idle_pct = 24;
    set_limits(9'd256, 9'd200, 9'd150);
    random_burst(400, 85);
    drain_results();

    // Drain phase: mostly allocates from a full list down to empty. The alarm can only
    // rise on the allocate that takes the last free handler.
    sender_idle_pct = 48;
    set_limits(9'd256, 9'd256, 9'd0);
    random_burst(400, 15);
    drain_results();

    // No sender gaps from here. With a zero total and zero critical level a grant raises
    // whenever the flag is clear, and a release clears whenever the flag is set.
    sender_idle_pct = 0;
    set_limits(9'd0, 9'd0, 9'd256);
    random_burst(80, 50);
    drain_results();

    // Random thresholds over the full range, each with its own allocate/release balance.
    repeat (3) begin
      set_limits(hfl_pkg::CFG_W'($urandom_range(256)),
                 hfl_pkg::CFG_W'($urandom_range(256)),
                 hfl_pkg::CFG_W'($urandom_range(256)));
      random_burst(80, 25 * $urandom_range(3, 1));
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
